[hw/rtl/skm_pkg.sv]
// Shared constants for the multichannel scalar Kalman smoother.
package skm_pkg;

	localparam int DATA_W     = 32;
	localparam int CH_FIELD_W = 3;
	localparam int GAIN_W     = 17;
	localparam int CFG_IDX_W  = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_ERR_MAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE_MAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_ERR_AUX    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE_AUX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_ERR_MAIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_ERR_AUX    = 3'd5;

	// register reset values, unsigned Q16.16
	localparam logic [DATA_W-1:0] MEAS_ERR_RST   = 32'd65536;
	localparam logic [DATA_W-1:0] PROC_NOISE_RST = 32'd655;
	localparam logic [DATA_W-1:0] INIT_ERR_RST   = 32'd65536;

	// unity gain in Q1.16
	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

	// serial step counts
	localparam int DIV_STEPS = 17;
	localparam int MUL_SHORT = 17;
	localparam int MUL_LONG  = 32;

endpackage

[hw/rtl/scalar_kalman_multichannel_core.sv]
// Multichannel scalar Kalman smoother: bit-serial divider and shift-add multiplier.
//
// Each input transfer carries a channel, a measurement and the prior estimate; the block
// returns one result transfer with the corrected estimate and the gain it used, and updates
// that channel's estimate error. All arithmetic runs bit-serially through one restoring
// divider (one quotient bit per cycle) and one shift-add multiplier (one multiplier bit per
// cycle) that is shared by the three products. An item in a valid channel runs through
// these steps in order: the divider forms the gain, the multiplier forms the correction,
// the estimate is saturated, the multiplier forms (1 - gain) * err and then
// |prior - estimate| * q, and the new error is formed and stored as the result is
// registered; the block then returns to idle. A channel at or above CHANNELS skips the
// arithmetic, returns the prior with zero gain and leaves all state alone. The result sits
// in an output register, so the block may take the next item while a result still waits;
// a finished item holds until that register is free.
// Configuration writes are meant to happen while the block is idle; a write to an initial
// error register also reloads the estimate error of the channels it covers.
module scalar_kalman_multichannel_core #(
	parameter int CHANNELS = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [skm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [skm_pkg::DATA_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [skm_pkg::CH_FIELD_W-1:0]       channel,
	input  logic signed [skm_pkg::DATA_W-1:0]    measurement,
	input  logic signed [skm_pkg::DATA_W-1:0]    prior_estimate,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [skm_pkg::DATA_W-1:0]    estimate,
	output logic [skm_pkg::GAIN_W-1:0]           gain
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [4:0] DIV_LAST  = 5'(skm_pkg::DIV_STEPS - 1);
	localparam logic [4:0] MUL_SLAST = 5'(skm_pkg::MUL_SHORT - 1);
	localparam logic [4:0] MUL_LLAST = 5'(skm_pkg::MUL_LONG - 1);

	localparam logic signed [36:0] EST_MAX = 37'sd2147483647;
	localparam logic signed [36:0] EST_MIN = -37'sd2147483648;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MEST,
		S_EST,
		S_MT1,
		S_MT2,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] meas_err_main_q, proc_noise_main_q, meas_err_aux_q, proc_noise_aux_q;
	logic [31:0] init_err_main_q, init_err_aux_q;

	// per-channel estimate error
	logic [31:0] est_err_q [CHANNELS];

	// item context
	logic [CH_W-1:0]    ch_q;
	logic               ch_ok_q;
	logic signed [31:0] meas_q, prior_q;
	logic [31:0]        err_q, q_q;

	// divider
	logic [32:0] den_q, rem_q;
	logic        den_zero_q;
	logic [16:0] nb_q;
	logic [16:0] gain_q;

	// multiplier
	logic signed [33:0] mc_q;
	logic [31:0]        mb_q;
	logic signed [34:0] hi_q;
	logic [16:0]        sp_q;
	logic [4:0]         cnt_q;

	logic signed [31:0] est_q;
	logic [32:0]        t1_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] estimate_q;
	logic [16:0]        gain_out_q;

	// accept-side decode
	logic            in_xfer;
	logic            ch_in_ok;
	logic [CH_W-1:0] ch_in;
	logic [31:0]     err_rd, merr_sel, q_sel;
	logic [32:0]     den_in;

	// divider step
	logic [33:0] div_trial;
	logic [34:0] div_diff;
	logic        qbit;
	logic [32:0] rem_next;
	logic [16:0] gain_div, gain_fin;

	// multiplier step
	logic signed [35:0] mul_sum;
	logic signed [32:0] diff;

	// estimate, deviation and new error
	logic signed [35:0] corr;
	logic signed [36:0] est_wide;
	logic signed [31:0] est_sat;
	logic signed [32:0] dev_d;
	logic [32:0]        dev_abs;
	logic [47:0]        t2;
	logic [48:0]        err_sum;
	logic [31:0]        err_new;
	logic               out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign estimate  = estimate_q;
	assign gain      = gain_out_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		ch_in    = CH_W'(channel);
		ch_in_ok = ({29'd0, channel} < 32'(CHANNELS));
		err_rd   = est_err_q[ch_in];
		merr_sel = (channel == '0) ? meas_err_aux_q : meas_err_main_q;
		q_sel    = (channel == '0) ? proc_noise_aux_q : proc_noise_main_q;
		den_in   = {1'b0, err_rd} + {1'b0, merr_sel};
	end

	// restoring division: gain = (err << 16) / (err + meas_err)
	always_comb begin
		div_trial = {rem_q, nb_q[16]};
		div_diff  = {1'b0, div_trial} - {2'b00, den_q};
		qbit      = !div_diff[34];
		rem_next  = qbit ? div_diff[32:0] : div_trial[32:0];
		gain_div  = {gain_q[15:0], qbit};
		gain_fin  = den_zero_q ? '0 : gain_div;
	end

	// shift-add step; the low bits drop into sp_q, so hi_q stays floored
	always_comb begin
		mul_sum = {hi_q[34], hi_q} + (mb_q[0] ? {{2{mc_q[33]}}, mc_q} : 36'sd0);
		diff    = {meas_q[31], meas_q} - {prior_q[31], prior_q};
	end

	always_comb begin
		corr     = $signed({hi_q, sp_q[16]});
		est_wide = {{5{prior_q[31]}}, prior_q} + {corr[35], corr};
		if (est_wide > EST_MAX) begin
			est_sat = 32'sh7FFF_FFFF;
		end else if (est_wide < EST_MIN) begin
			est_sat = 32'sh8000_0000;
		end else begin
			est_sat = est_wide[31:0];
		end
		dev_d   = {prior_q[31], prior_q} - {est_q[31], est_q};
		dev_abs = dev_d[32] ? (33'd0 - dev_d) : dev_d;
		t2      = {hi_q[31:0], sp_q[16:1]};
		err_sum = {16'd0, t1_q} + {1'b0, t2};
		err_new = (|err_sum[48:32]) ? 32'hFFFF_FFFF : err_sum[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			out_valid_q       <= 1'b0;
			meas_err_main_q   <= skm_pkg::MEAS_ERR_RST;
			proc_noise_main_q <= skm_pkg::PROC_NOISE_RST;
			meas_err_aux_q    <= skm_pkg::MEAS_ERR_RST;
			proc_noise_aux_q  <= skm_pkg::PROC_NOISE_RST;
			init_err_main_q   <= skm_pkg::INIT_ERR_RST;
			init_err_aux_q    <= skm_pkg::INIT_ERR_RST;
			for (int i = 0; i < CHANNELS; i++) begin
				est_err_q[i] <= skm_pkg::INIT_ERR_RST;
			end
		end else begin
			// configuration: an initial error write reloads its channels
			if (cfg_wr_en) begin
				unique case (cfg_index)
					skm_pkg::REG_MEAS_ERR_MAIN:   meas_err_main_q   <= cfg_data;
					skm_pkg::REG_PROC_NOISE_MAIN: proc_noise_main_q <= cfg_data;
					skm_pkg::REG_MEAS_ERR_AUX:    meas_err_aux_q    <= cfg_data;
					skm_pkg::REG_PROC_NOISE_AUX:  proc_noise_aux_q  <= cfg_data;
					skm_pkg::REG_INIT_ERR_MAIN: begin
						init_err_main_q <= cfg_data;
						for (int i = 1; i < CHANNELS; i++) begin
							est_err_q[i] <= cfg_data;
						end
					end
					skm_pkg::REG_INIT_ERR_AUX: begin
						init_err_aux_q <= cfg_data;
						est_err_q[0]   <= cfg_data;
					end
					default: ;
				endcase
			end

			// drop the result once its transfer completes
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						ch_q    <= ch_in;
						ch_ok_q <= ch_in_ok;
						meas_q  <= measurement;
						prior_q <= prior_estimate;
						if (ch_in_ok) begin
							err_q      <= err_rd;
							q_q        <= q_sel;
							den_q      <= den_in;
							den_zero_q <= (den_in == '0);
							rem_q      <= {2'b00, err_rd[31:1]};
							nb_q       <= {err_rd[0], 16'd0};
							gain_q     <= '0;
							cnt_q      <= DIV_LAST;
							state_q    <= S_DIV;
						end else begin
							// out-of-range channel: pass the prior through
							est_q   <= prior_estimate;
							gain_q  <= '0;
							state_q <= S_DONE;
						end
					end
				end
				S_DIV: begin
					rem_q <= rem_next;
					nb_q  <= {nb_q[15:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						gain_q  <= gain_fin;
						mb_q    <= 32'(gain_fin);
						mc_q    <= {diff[32], diff};
						hi_q    <= '0;
						cnt_q   <= MUL_SLAST;
						state_q <= S_MEST;
					end else begin
						gain_q <= gain_div;
					end
				end
				S_MEST, S_MT1, S_MT2: begin
					hi_q  <= mul_sum[35:1];
					sp_q  <= {mul_sum[0], sp_q[16:1]};
					mb_q  <= {1'b0, mb_q[31:1]};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						if (state_q == S_MEST) begin
							state_q <= S_EST;
						end else if (state_q == S_MT1) begin
							// advance to |prior - estimate| * q
							t1_q    <= mul_sum[32:0];
							mb_q    <= q_q;
							mc_q    <= {1'b0, dev_abs};
							hi_q    <= '0;
							cnt_q   <= MUL_LLAST;
							state_q <= S_MT2;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_EST: begin
					// saturate the estimate, then start (1 - gain) * err
					est_q   <= est_sat;
					mb_q    <= 32'(skm_pkg::GAIN_ONE - gain_q);
					mc_q    <= {2'b00, err_q};
					hi_q    <= '0;
					cnt_q   <= MUL_SLAST;
					state_q <= S_MT1;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						estimate_q  <= est_q;
						gain_out_q  <= gain_q;
						out_valid_q <= 1'b1;
						if (ch_ok_q) begin
							est_err_q[ch_q] <= err_new;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/skm_checker.sv]
// Port-level checks for the multichannel scalar Kalman smoother, bound to the top level.
module skm_port_checks (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [skm_pkg::DATA_W-1:0] estimate,
	input logic [skm_pkg::GAIN_W-1:0]        gain
);

	// one item at a time: a transfer closes the input side
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again straight after a transfer");

	// no result rises in the cycle after its input transfer
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared in the cycle after an input transfer");

	// gain never exceeds one
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gain <= skm_pkg::GAIN_ONE))
		else $error("gain above one");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(estimate) && $stable(gain))
		else $error("stalled result changed");

endmodule

bind scalar_kalman_multichannel_core skm_port_checks u_skm_port_checks (.*);

[dv/skm_checker.sv]
// Result checker for the multichannel Kalman smoother: tracks per-channel error and compares.
module skm_checker
	import skm_pkg::*;
#(
	parameter int CHANNELS = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [DATA_W-1:0]            cfg_data,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [CH_FIELD_W-1:0]        channel,
	input  logic signed [DATA_W-1:0]     measurement,
	input  logic signed [DATA_W-1:0]     prior_estimate,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic signed [DATA_W-1:0]     estimate,
	input  logic [GAIN_W-1:0]            gain,
	output int unsigned                  mismatches,
	output int unsigned                  awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [DATA_W-1:0] estimate;
		logic [GAIN_W-1:0]        gain;
	} smooth_out_t;

	logic [DATA_W-1:0] merr_main, q_main, merr_aux, q_aux, init_main, init_aux;
	logic [DATA_W-1:0] err_track [CHANNELS];
	smooth_out_t       awaited_corrections [$];

	function automatic logic signed [63:0] widen(input logic signed [DATA_W-1:0] v);
		return {{(64-DATA_W){v[DATA_W-1]}}, v};
	endfunction

	// Work out one correction and advance that channel's estimate error.
	function automatic smooth_out_t smooth_sample(input logic [CH_FIELD_W-1:0] ch,
			input logic signed [DATA_W-1:0] meas, input logic signed [DATA_W-1:0] prior);
		logic [DATA_W-1:0]  err, merr, q;
		logic [DATA_W:0]    den;
		logic [63:0]        g, dev, t1, t2, total;
		logic signed [63:0] corr, est;
		smooth_out_t        res;
		if (ch >= CHANNELS) begin
			res.estimate = prior;
			res.gain     = '0;
			return res;
		end
		err  = err_track[ch];
		merr = (ch == 0) ? merr_aux : merr_main;
		q    = (ch == 0) ? q_aux : q_main;
		den  = {1'b0, err} + {1'b0, merr};
		g    = (den == '0) ? 64'd0 : {16'b0, err, 16'b0} / {31'b0, den};
		corr = ($signed(g) * (widen(meas) - widen(prior))) >>> 16;
		est  = widen(prior) + corr;
		if (est > 64'sh7FFF_FFFF)
			est = 64'sh7FFF_FFFF;
		if (est < -64'sh8000_0000)
			est = -64'sh8000_0000;
		dev   = (widen(prior) >= est) ? widen(prior) - est : est - widen(prior);
		t1    = ((64'd65536 - g) * {32'b0, err}) >> 16;
		t2    = (dev * {32'b0, q}) >> 16;
		total = t1 + t2;
		if (total > 64'hFFFF_FFFF)
			total = 64'hFFFF_FFFF;
		err_track[ch] = total[DATA_W-1:0];
		res.estimate  = est[DATA_W-1:0];
		res.gain      = g[GAIN_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		smooth_out_t want;
		int          miss;
		miss = 0;
		if (!arst_n) begin
			merr_main = MEAS_ERR_RST;
			q_main    = PROC_NOISE_RST;
			merr_aux  = MEAS_ERR_RST;
			q_aux     = PROC_NOISE_RST;
			init_main = INIT_ERR_RST;
			init_aux  = INIT_ERR_RST;
			for (int i = 0; i < CHANNELS; i++)
				err_track[i] = (i == 0) ? init_aux : init_main;
			awaited_corrections.delete();
			mismatches <= 0;
			awaited    <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MEAS_ERR_MAIN:   merr_main = cfg_data;
					REG_PROC_NOISE_MAIN: q_main    = cfg_data;
					REG_MEAS_ERR_AUX:    merr_aux  = cfg_data;
					REG_PROC_NOISE_AUX:  q_aux     = cfg_data;
					REG_INIT_ERR_MAIN: begin
						init_main = cfg_data;
						for (int i = 1; i < CHANNELS; i++)
							err_track[i] = cfg_data;
					end
					REG_INIT_ERR_AUX: begin
						init_aux     = cfg_data;
						err_track[0] = cfg_data;
					end
					default: ;
				endcase
			end
			// take the result first so that it never meets the item entering this cycle
			if (out_valid && !out_stall) begin
				if (awaited_corrections.size() == 0) begin
					$error("result transfer with no sample outstanding: estimate %0d gain %0d",
						estimate, gain);
					miss++;
				end else begin
					want = awaited_corrections.pop_front();
					if (want.estimate !== estimate) begin
						$error("estimate: expected %0d, actual %0d", want.estimate, estimate);
						miss++;
					end
					if (want.gain !== gain) begin
						$error("gain: expected %0d, actual %0d", want.gain, gain);
						miss++;
					end
				end
			end
			if (in_valid && !in_stall)
				awaited_corrections.push_back(smooth_sample(channel, measurement,
					prior_estimate));
			mismatches <= mismatches + miss;
			awaited    <= awaited_corrections.size();
		end
	end

endmodule

[dv/scalar_kalman_multichannel_core_tb.sv]
// Testbench top for the multichannel Kalman smoother core: stimulus, back-pressure and verdict.
module scalar_kalman_multichannel_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import skm_pkg::*;

	localparam int CHANNELS            = 5;
	localparam int CFG_SETS            = 6;
	localparam int SAMPLES_PER_SETTING = 300;
	localparam int HOLD_EVERY          = 600;   // results between the long receiver hold-offs
	localparam int LONG_HOLD           = 400;
	localparam int QUIET_LIMIT         = 5000;  // cycles without any transfer before giving up
	localparam int DRAIN_TAIL          = 100;

	// indexes with no register behind them; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// kinds of register setting used by the random phases
	localparam int SET_RESET = 0;
	localparam int SET_ZERO  = 1;
	localparam int SET_FULL  = 2;

	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

	logic                        clk            = 1'b0;
	logic                        arst_n         = 1'b0;
	logic                        cfg_wr_en      = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index      = '0;
	logic [DATA_W-1:0]           cfg_data       = '0;
	logic                        in_valid       = 1'b0;
	logic                        in_stall;
	logic [CH_FIELD_W-1:0]       channel        = '0;
	logic signed [DATA_W-1:0]    measurement    = '0;
	logic signed [DATA_W-1:0]    prior_estimate = '0;
	logic                        out_valid;
	logic                        out_stall      = 1'b0;
	logic signed [DATA_W-1:0]    estimate;
	logic [GAIN_W-1:0]           gain;

	int unsigned mismatches;
	int unsigned awaited;
	int          results_taken = 0;
	int          quiet_cycles  = 0;
	int          samples_sent  = 0;
	int          off_range     = 0;

	always #6 clk = ~clk;

	scalar_kalman_multichannel_core #(
		.CHANNELS(CHANNELS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.channel       (channel),
		.measurement   (measurement),
		.prior_estimate(prior_estimate),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.estimate      (estimate),
		.gain          (gain)
	);

	skm_checker #(
		.CHANNELS(CHANNELS)
	) result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.channel       (channel),
		.measurement   (measurement),
		.prior_estimate(prior_estimate),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.estimate      (estimate),
		.gain          (gain),
		.mismatches    (mismatches),
		.awaited       (awaited)
	);

	// Count result transfers and watch for a hang: any transfer or register write
	// clears the quiet counter, a long enough silence ends the run.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			results_taken <= results_taken + 1;
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Idle length between samples: mostly none or short, now and then a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 80)
			return $urandom_range(1, 4);
		if (r < 95)
			return $urandom_range(5, 30);
		return $urandom_range(31, 150);
	endfunction

	function automatic logic signed [DATA_W-1:0] edge_value();
		case ($urandom_range(0, 4))
			0:       return S32_MAX;
			1:       return S32_MIN;
			2:       return '0;
			3:       return '1;
			default: return 1;
		endcase
	endfunction

	// Register value for one setting kind; random settings favour zero, all-ones and
	// small values, where the gain and error arithmetic has its corners.
	function automatic logic [DATA_W-1:0] setting_value(input int kind,
			input logic [DATA_W-1:0] rst_val);
		int r;
		case (kind)
			SET_RESET: return rst_val;
			SET_ZERO:  return '0;
			SET_FULL:  return '1;
			default: begin
				r = $urandom_range(0, 9);
				if (r < 2)
					return '0;
				if (r < 4)
					return '1;
				if (r < 7)
					return $urandom_range(0, 32'h0002_0000);
				return $urandom;
			end
		endcase
	endfunction

	// Offer one sample after an optional idle gap and hold it until the transfer.
	task automatic push_sample(input logic [CH_FIELD_W-1:0] ch,
			input logic signed [DATA_W-1:0] meas, input logic signed [DATA_W-1:0] prior,
			input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		channel        <= ch;
		measurement    <= meas;
		prior_estimate <= prior;
		do
			@(posedge clk);
		while (in_stall);
		samples_sent++;
		if (ch >= CHANNELS)
			off_range++;
	endtask

	// Mostly tracking-style samples: a measurement close to the prior, so that the
	// error of each channel settles as it would in use. The rest is wide noise and
	// corner values, with a few indexes past the last channel.
	task automatic random_sample(input logic burst);
		logic [CH_FIELD_W-1:0]    ch;
		logic signed [DATA_W-1:0] prior, meas;
		int                       r;
		if ($urandom_range(0, 9) == 0)
			ch = CH_FIELD_W'($urandom_range(CHANNELS, 2**CH_FIELD_W - 1));
		else
			ch = CH_FIELD_W'($urandom_range(0, CHANNELS - 1));
		prior = $urandom;
		r     = $urandom_range(0, 99);
		if (r < 60) begin
			meas = prior + $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
		end else if (r < 85) begin
			meas = $urandom;
		end else begin
			meas  = edge_value();
			prior = edge_value();
		end
		push_sample(ch, meas, prior, burst ? 0 : pick_gap());
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid and hold until every outstanding result has been taken, then let
	// the core return to idle before touching its registers. The outstanding count
	// is registered and lags the last transfer, so the task steps past it first.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Receiver: random stall bursts, including runs with no stall at all. Twice in
	// the run hold off for a long stretch while the sender keeps going, so that the
	// output register and the core both fill and the input stalls.
	initial begin : result_sink
		int   span;
		int   holds;
		int   r;
		logic hold;
		holds = 0;
		forever begin
			if (holds < 2 && results_taken >= (holds + 1) * HOLD_EVERY) begin
				holds++;
				hold = 1'b1;
				span = LONG_HOLD;
			end else begin
				r = $urandom_range(0, 19);
				if (r < 8) begin
					hold = 1'b0;
					span = $urandom_range(1, 40);
				end else if (r < 17) begin
					hold = 1'b1;
					span = $urandom_range(1, 4);
				end else if (r < 19) begin
					hold = 1'b1;
					span = $urandom_range(5, 20);
				end else begin
					hold = 1'b1;
					span = $urandom_range(30, 120);
				end
			end
			repeat (span) begin
				@(posedge clk);
				out_stall <= hold;
			end
		end
	end

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: field extremes, every channel and the indexes past the last one.
		push_sample(0, 0, 0, 0);
		push_sample(1, S32_MAX, S32_MIN, 0);
		push_sample(2, S32_MIN, S32_MAX, 2);
		push_sample(3, -1, 1, 0);
		push_sample(4, 32'sh0001_0000, 32'sh0000_8000, 0);
		push_sample(5, S32_MAX, 32'sh1234_5678, 0);
		push_sample(6, 0, S32_MIN, 0);
		push_sample(7, S32_MIN, -1, 0);
		push_sample(0, S32_MAX, 0, 0);
		settle();

		// Zero error and zero measurement error on the aux channel give a zero
		// denominator; a full initial error with no measurement error on the main
		// channels gives unity gain, and a full process noise saturates the error.
		// The spare indexes get values that would show up if they aliased a register.
		write_reg(REG_MEAS_ERR_AUX, '0);
		write_reg(REG_INIT_ERR_AUX, '0);
		write_reg(REG_PROC_NOISE_AUX, '1);
		write_reg(REG_MEAS_ERR_MAIN, '0);
		write_reg(REG_PROC_NOISE_MAIN, '1);
		write_reg(REG_INIT_ERR_MAIN, '1);
		write_reg(REG_SPARE_LO, 32'h0000_0001);
		write_reg(REG_SPARE_HI, 32'h8000_0000);
		push_sample(0, S32_MAX, S32_MIN, 0);
		push_sample(0, 12345, -5, 0);
		push_sample(1, S32_MIN, S32_MAX, 0);
		push_sample(1, S32_MAX, S32_MIN, 0);
		// unity gain with no deviation clears the error, so the next one divides by zero
		push_sample(2, 0, 0, 0);
		push_sample(2, 100, 0, 0);
		push_sample(4, -1, S32_MAX, 0);
		push_sample(5, 1, 2, 0);
		settle();

		// Random phases, one register setting each: reset values, all zero, all ones,
		// then random mixes. Every phase writes all six registers.
		for (int set = 0; set < CFG_SETS; set++) begin
			write_reg(REG_MEAS_ERR_MAIN, setting_value(set, MEAS_ERR_RST));
			write_reg(REG_PROC_NOISE_MAIN, setting_value(set, PROC_NOISE_RST));
			write_reg(REG_MEAS_ERR_AUX, setting_value(set, MEAS_ERR_RST));
			write_reg(REG_PROC_NOISE_AUX, setting_value(set, PROC_NOISE_RST));
			write_reg(REG_INIT_ERR_MAIN, setting_value(set, INIT_ERR_RST));
			write_reg(REG_INIT_ERR_AUX, setting_value(set, INIT_ERR_RST));
			// the first quarter of every hundred samples goes back to back
			for (int k = 0; k < SAMPLES_PER_SETTING; k++)
				random_sample((k % 100) < 25);
			settle();
		end

		repeat (DRAIN_TAIL) @(posedge clk);
		$display("Covered %0d sample transfers (%0d past the last channel) and %0d results,",
			samples_sent, off_range, results_taken);
		$display("over %0d random register settings plus the directed corner settings.",
			CFG_SETS);
		if (mismatches == 0 && awaited == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
